@@ src/gpra_pkg.sv @@
// Package for the Gaussian PSF residual accumulator: widths, register indexes,
// controller state type, command struct and the exp table function.
// No dependencies.
`timescale 1ns / 1ps
package gpra_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RESID_W  = 17;
    localparam int SUM_W    = 29;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 29;

    localparam logic [RESID_W-1:0] RESID_MAX = {RESID_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BACKGROUND = 3'd0,
        REG_AMPLITUDE  = 3'd1,
        REG_CENTER_X   = 3'd2,
        REG_CENTER_Y   = 3'd3,
        REG_COEF_XX    = 3'd4,
        REG_COEF_XY    = 3'd5,
        REG_COEF_YY    = 3'd6,
        REG_BEST       = 3'd7
    } reg_idx_t;

    // Controller states: idle, one per datapath step of a request, and output.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_SQUARE,
        ST_QMUL,
        ST_QSUM,
        ST_LOG2,
        ST_ROM,
        ST_AMP,
        ST_RESID,
        ST_ACCUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;   // capture the incoming request
        logic delta;  // dx, dy
        logic square; // dx^2, dx*dy, dy^2
        logic qmul;   // coefficient products
        logic qsum;   // sum of products
        logic log2;   // scale by log2(e)
        logic rom;    // table lookup and shift
        logic amp;    // amplitude times exp
        logic resid;  // absolute residual
        logic accum;  // running sum and stop flag
        logic step;   // advance position after delivery
    } cmd_t;

    // Taylor series build of 65536*2^(-i/depth), evaluated at elaboration.
    function automatic logic [16:0] exp_rom(input int unsigned i, input int unsigned depth);
        logic [63:0] y;
        logic [63:0] term;
        longint acc;
        longint unsigned ys;
        y = (64'(i) * 64'd2977044472) / 64'(depth);
        term = 64'd1 << 32;
        acc = longint'(term);
        for (int n = 1; n <= 24; n++) begin
            ys = ((term * y) >> 32);
            term = ys / 64'(n);
            if ((n % 2) == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        return 17'((64'(acc) + 64'd32768) >> 16);
    endfunction

endpackage

@@ src/gpra_ctrl.sv @@
// Controller of the residual accumulator: steps one request through the datapath.
// Depends on gpra_pkg.
`timescale 1ns / 1ps
module gpra_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            out_taken,
    output logic            in_ready,
    output logic            out_valid,
    output gpra_pkg::cmd_t  cmd
);

    gpra_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gpra_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gpra_pkg::ST_IDLE:   if (in_fire) state_next = gpra_pkg::ST_DELTA;
            gpra_pkg::ST_DELTA:  state_next = gpra_pkg::ST_SQUARE;
            gpra_pkg::ST_SQUARE: state_next = gpra_pkg::ST_QMUL;
            gpra_pkg::ST_QMUL:   state_next = gpra_pkg::ST_QSUM;
            gpra_pkg::ST_QSUM:   state_next = gpra_pkg::ST_LOG2;
            gpra_pkg::ST_LOG2:   state_next = gpra_pkg::ST_ROM;
            gpra_pkg::ST_ROM:    state_next = gpra_pkg::ST_AMP;
            gpra_pkg::ST_AMP:    state_next = gpra_pkg::ST_RESID;
            gpra_pkg::ST_RESID:  state_next = gpra_pkg::ST_ACCUM;
            gpra_pkg::ST_ACCUM:  state_next = gpra_pkg::ST_OUT;
            gpra_pkg::ST_OUT:    if (out_taken) state_next = gpra_pkg::ST_IDLE;
            default:             state_next = gpra_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            gpra_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_fire;
            end
            gpra_pkg::ST_DELTA:  cmd.delta  = 1'b1;
            gpra_pkg::ST_SQUARE: cmd.square = 1'b1;
            gpra_pkg::ST_QMUL:   cmd.qmul   = 1'b1;
            gpra_pkg::ST_QSUM:   cmd.qsum   = 1'b1;
            gpra_pkg::ST_LOG2:   cmd.log2   = 1'b1;
            gpra_pkg::ST_ROM:    cmd.rom    = 1'b1;
            gpra_pkg::ST_AMP:    cmd.amp    = 1'b1;
            gpra_pkg::ST_RESID:  cmd.resid  = 1'b1;
            gpra_pkg::ST_ACCUM:  cmd.accum  = 1'b1;
            gpra_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                cmd.step  = out_taken;
            end
            default: ;
        endcase
    end

endmodule

@@ src/gpra_dp.sv @@
// Datapath of the residual accumulator: model evaluation, residual and sum.
// Depends on gpra_pkg.
`timescale 1ns / 1ps
module gpra_dp
#(
    parameter int MAX_WIDTH       = 64,
    parameter int MAX_HEIGHT      = 64,
    parameter int EXP_TABLE_DEPTH = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  gpra_pkg::cmd_t      cmd,
    input  logic [15:0]         sample,
    input  logic                end_of_row,
    input  logic                end_of_window,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_idx,
    input  logic [28:0]         cfg_data,
    output logic [16:0]         residual,
    output logic [28:0]         running_sum,
    output logic                bound_reached,
    output logic                last
);

    localparam int COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
    localparam int D_W   = ((COL_W > ROW_W) ? COL_W : ROW_W) + 11;
    localparam int P_W   = 2 * D_W;
    localparam int Q_W   = P_W + 23;

    // The exp table is built once at elaboration and packed into one constant.
    function automatic logic [EXP_TABLE_DEPTH*17-1:0] build_exp_table();
        logic [EXP_TABLE_DEPTH*17-1:0] tbl;
        tbl = '0;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++)
            tbl[i*17 +: 17] = gpra_pkg::exp_rom(i, EXP_TABLE_DEPTH);
        return tbl;
    endfunction

    localparam logic [EXP_TABLE_DEPTH*17-1:0] EXP_TBL = build_exp_table();

    // Configuration registers.
    logic signed [16:0] background_reg, amplitude_reg;
    logic signed [15:0] center_x_reg, center_y_reg;
    logic [19:0]        coef_xx_reg, coef_yy_reg;
    logic signed [20:0] coef_xy_reg;
    logic [28:0]        best_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            background_reg <= '0;
            amplitude_reg  <= '0;
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            coef_xx_reg    <= '0;
            coef_xy_reg    <= '0;
            coef_yy_reg    <= '0;
            best_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (gpra_pkg::reg_idx_t'(cfg_idx))
                gpra_pkg::REG_BACKGROUND: background_reg <= cfg_data[16:0];
                gpra_pkg::REG_AMPLITUDE:  amplitude_reg  <= cfg_data[16:0];
                gpra_pkg::REG_CENTER_X:   center_x_reg   <= cfg_data[15:0];
                gpra_pkg::REG_CENTER_Y:   center_y_reg   <= cfg_data[15:0];
                gpra_pkg::REG_COEF_XX:    coef_xx_reg    <= cfg_data[19:0];
                gpra_pkg::REG_COEF_XY:    coef_xy_reg    <= cfg_data[20:0];
                gpra_pkg::REG_COEF_YY:    coef_yy_reg    <= cfg_data[19:0];
                gpra_pkg::REG_BEST:       best_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // Window position and accumulator state.
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [28:0]      sum_reg;
    logic             stop_reg;

    // Captured request.
    logic [15:0] sample_reg;
    logic        eor_reg, eow_reg;

    // Pipeline-by-step registers.
    logic signed [D_W-1:0]  dx_reg, dy_reg;
    logic signed [P_W-1:0]  pxx_reg, pxy_reg, pyy_reg;
    logic signed [Q_W-1:0]  qxx_reg, qxy_reg, qyy_reg;
    logic signed [Q_W-1:0]  q_reg;
    logic                   qneg_reg, qbig_reg;
    logic [53:0]            t_reg;
    logic [16:0]            e_reg;
    logic [16:0]            am_reg;
    logic [16:0]            resid_reg;

    logic signed [Q_W-1:0] q_sum;
    logic [Q_W+16:0]       t_full;
    logic [IDX_W-1:0]      rom_idx;
    logic [21:0]           k_val;
    logic [16:0]           rom_val;
    logic [33:0]           am_full;
    logic signed [19:0]    diff;
    logic [19:0]           diff_abs;
    logic [29:0]           sum_add;
    logic [28:0]           sum_sat;

    assign q_sum   = qxx_reg + qxy_reg + qyy_reg;
    assign t_full  = (Q_W+17)'(q_reg[Q_W-1:0]) * (Q_W+17)'(94548);
    assign k_val   = t_reg[53:32];
    assign rom_idx = t_reg[31:32-IDX_W];
    assign rom_val = EXP_TBL[32'(rom_idx) * 17 +: 17];
    assign am_full = 34'(amplitude_reg[15:0]) * 34'(e_reg) + 34'd32768;
    assign diff    = 20'(signed'({1'b0, sample_reg})) - 20'(background_reg)
                     - 20'(signed'({1'b0, am_reg}));
    assign diff_abs = diff[19] ? 20'(-diff) : 20'(diff);
    assign sum_add = 30'(sum_reg) + 30'(resid_reg);
    assign sum_sat = sum_add[29] ? gpra_pkg::SUM_MAX : sum_add[28:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample;
            eor_reg    <= end_of_row;
            eow_reg    <= end_of_window;
        end
        if (cmd.delta)
        begin
            dx_reg <= D_W'(signed'({1'b0, col_reg, 8'd0})) - D_W'(center_x_reg);
            dy_reg <= D_W'(signed'({1'b0, row_reg, 8'd0})) - D_W'(center_y_reg);
        end
        if (cmd.square)
        begin
            pxx_reg <= dx_reg * dx_reg;
            pxy_reg <= dx_reg * dy_reg;
            pyy_reg <= dy_reg * dy_reg;
        end
        if (cmd.qmul)
        begin
            qxx_reg <= Q_W'(signed'({1'b0, coef_xx_reg})) * Q_W'(pxx_reg);
            qxy_reg <= (Q_W'(coef_xy_reg) * Q_W'(pxy_reg)) <<< 1;
            qyy_reg <= Q_W'(signed'({1'b0, coef_yy_reg})) * Q_W'(pyy_reg);
        end
        if (cmd.qsum)
        begin
            q_reg    <= q_sum;
            qneg_reg <= (q_sum <= 0);
            qbig_reg <= (q_sum >= (Q_W'(32) <<< 32));
        end
        if (cmd.log2)
            t_reg <= 54'(t_full >> 16);
        if (cmd.rom)
        begin
            if (qneg_reg)
                e_reg <= 17'd65536;
            else if (qbig_reg || k_val >= 22'd17)
                e_reg <= '0;
            else
                e_reg <= rom_val >> k_val[4:0];
        end
        if (cmd.amp)
            am_reg <= am_full[32:16];
        if (cmd.resid)
        begin
            if (background_reg[16] || amplitude_reg[16])
                resid_reg <= gpra_pkg::RESID_MAX;
            else if (diff_abs > 20'(gpra_pkg::RESID_MAX))
                resid_reg <= gpra_pkg::RESID_MAX;
            else
                resid_reg <= diff_abs[16:0];
        end
    end

    // Sum, stop flag and position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            sum_reg  <= '0;
            stop_reg <= 1'b0;
        end
        else if (cmd.accum)
        begin
            if (!stop_reg)
            begin
                sum_reg <= sum_sat;
                if (best_reg != '0 && sum_sat >= best_reg)
                    stop_reg <= 1'b1;
            end
        end
        else if (cmd.step)
        begin
            priority if (eow_reg)
            begin
                col_reg  <= '0;
                row_reg  <= '0;
                sum_reg  <= '0;
                stop_reg <= 1'b0;
            end
            else if (eor_reg)
            begin
                col_reg <= '0;
                if (row_reg != ROW_W'(MAX_HEIGHT - 1))
                    row_reg <= row_reg + 1'b1;
            end
            else if (col_reg != COL_W'(MAX_WIDTH - 1))
                col_reg <= col_reg + 1'b1;
        end
    end

    assign residual      = resid_reg;
    assign running_sum   = sum_reg;
    assign bound_reached = stop_reg;
    assign last          = eow_reg;

endmodule

@@ src/gaussian_psf_residual_accumulator.sv @@
// The controller walks each request through the steps of the datapath, one
// step a cycle, then waits for the result to be taken; no new request is
// accepted before then. Reset (rst_n low, asynchronous) clears the
// configuration registers, controller state, position, sum and stop flag.
// Depends on gpra_pkg, gpra_ctrl and gpra_dp.
`timescale 1ns / 1ps
module gaussian_psf_residual_accumulator
#(
    parameter int MAX_WIDTH       = 64,
    parameter int MAX_HEIGHT      = 64,
    parameter int EXP_TABLE_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // sample
    input  logic        s_axis_tuser,   // end_of_row
    input  logic        s_axis_tlast,   // end_of_window
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // residual[16:0], running_sum[45:17], zeros
    output logic        m_axis_tuser,   // bound_reached
    output logic        m_axis_tlast,   // last
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [28:0] cfg_data
);

    gpra_pkg::cmd_t cmd;
    logic [16:0] residual;
    logic [28:0] running_sum;
    logic in_fire, out_taken;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_taken = m_axis_tvalid && m_axis_tready;

    gpra_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_taken (out_taken),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .cmd       (cmd)
    );

    gpra_dp #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sample        (s_axis_tdata),
        .end_of_row    (s_axis_tuser),
        .end_of_window (s_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_data      (cfg_data),
        .residual      (residual),
        .running_sum   (running_sum),
        .bound_reached (m_axis_tuser),
        .last          (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, running_sum, residual};

    // Never ready for input while a result is pending.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    // An accepted request leaves the idle state.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("accepted twice");

    // Once stopped, the sum is frozen until the result is taken.
    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser && !m_axis_tready) |=> $stable(m_axis_tdata[45:17]))
        else $error("sum changed while stopped");

endmodule
